// ===== hdl/ctp_pkg.sv =====
`timescale 1ns / 1ps
package ctp_pkg;

  localparam int unsigned NCHAN  = 7;
  localparam int unsigned CH_W   = 3;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned PER_W  = 16;
  localparam int unsigned NODE_W = 6;
  localparam int unsigned CMD_W  = 5;
  localparam int unsigned ID_W   = NODE_W + CMD_W;
  localparam int unsigned NPER   = 6;

  localparam int unsigned TORQUE_PERIOD_DEF = 100;
  localparam int unsigned LINK_TIMEOUT_DEF  = 1500;
  localparam logic [PER_W-1:0] PERIOD_RST = 16'd100;

  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_FRAME = 1'b1;
  localparam logic KIND_REQ  = 1'b0;
  localparam logic KIND_UPD  = 1'b1;

  localparam logic [3:0] LEN_WORD = 4'd4;
  localparam logic [3:0] LEN_FULL = 4'd8;

  localparam logic [CMD_W-1:0] CMD_HEARTBEAT = 5'h01;
  localparam logic [CMD_W-1:0] CMD_ERROR     = 5'h03;
  localparam logic [CMD_W-1:0] CMD_ENCODER   = 5'h09;
  localparam logic [CMD_W-1:0] CMD_IQ        = 5'h14;
  localparam logic [CMD_W-1:0] CMD_TEMP      = 5'h15;
  localparam logic [CMD_W-1:0] CMD_VBUS      = 5'h17;
  localparam logic [CMD_W-1:0] CMD_TORQUE    = 5'h1C;

  localparam logic [CH_W-1:0] CH_STATE  = 3'd0;
  localparam logic [CH_W-1:0] CH_TORQUE = 3'd6;

  typedef enum logic [2:0] {
    REG_NODE_ID   = 3'd0,
    REG_HB_PER    = 3'd1,
    REG_STATE_PER = 3'd2,
    REG_ERROR_PER = 3'd3,
    REG_ENC_PER   = 3'd4,
    REG_IQ_PER    = 3'd5,
    REG_TEMP_PER  = 3'd6,
    REG_VBUS_PER  = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HB,
    ST_FLUSH
  } eng_state_t;

  typedef struct packed {
    logic [NODE_W-1:0]          node_id;
    logic [PER_W-1:0]           hb_period;
    logic [NPER-1:0][PER_W-1:0] chan_period;
  } cfg_t;

  typedef struct packed {
    logic        action;
    logic        tx_ready;
    logic [10:0] frame_id;
    logic [3:0]  frame_len;
    logic [63:0] frame_data;
  } item_t;

  typedef struct packed {
    logic            kind;
    logic [ID_W-1:0] out_id;
    logic [CH_W-1:0] channel;
    logic [31:0]     word_a;
    logic [31:0]     word_b;
    logic [7:0]      state_byte;
    logic [7:0]      result_byte;
    logic            link_ok;
    logic            last;
  } res_t;

  typedef struct packed {
    logic idle;
    logic pend_valid;
  } eng_stat_t;

  typedef struct packed {
    logic            hit;
    logic [CH_W-1:0] ch;
  } chan_hit_t;

  function automatic logic [CMD_W-1:0] chan_cmd(input logic [CH_W-1:0] c);
    logic [CMD_W-1:0] r;
    case (c)
      3'd0:    r = CMD_HEARTBEAT;
      3'd1:    r = CMD_ERROR;
      3'd2:    r = CMD_ENCODER;
      3'd3:    r = CMD_IQ;
      3'd4:    r = CMD_TEMP;
      3'd5:    r = CMD_VBUS;
      default: r = CMD_TORQUE;
    endcase
    return r;
  endfunction

  function automatic chan_hit_t cmd_chan(input logic [CMD_W-1:0] cmd);
    chan_hit_t r;
    r.hit = 1'b1;
    case (cmd)
      CMD_HEARTBEAT: r.ch = 3'd0;
      CMD_ERROR:     r.ch = 3'd1;
      CMD_ENCODER:   r.ch = 3'd2;
      CMD_IQ:        r.ch = 3'd3;
      CMD_TEMP:      r.ch = 3'd4;
      CMD_VBUS:      r.ch = 3'd5;
      CMD_TORQUE:    r.ch = 3'd6;
      default: begin
        r.hit = 1'b0;
        r.ch  = CH_STATE;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/ctp_ram.sv =====
`timescale 1ns / 1ps
module ctp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/ctp_regs.sv =====
`timescale 1ns / 1ps
module ctp_regs
  import ctp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_id     <= '0;
      cfg.hb_period   <= PERIOD_RST;
      cfg.chan_period <= {NPER{PERIOD_RST}};
    end else if (wr) begin
      unique case (idx)
        REG_NODE_ID:   cfg.node_id        <= pwdata[NODE_W-1:0];
        REG_HB_PER:    cfg.hb_period      <= pwdata[PER_W-1:0];
        REG_STATE_PER: cfg.chan_period[0] <= pwdata[PER_W-1:0];
        REG_ERROR_PER: cfg.chan_period[1] <= pwdata[PER_W-1:0];
        REG_ENC_PER:   cfg.chan_period[2] <= pwdata[PER_W-1:0];
        REG_IQ_PER:    cfg.chan_period[3] <= pwdata[PER_W-1:0];
        REG_TEMP_PER:  cfg.chan_period[4] <= pwdata[PER_W-1:0];
        REG_VBUS_PER:  cfg.chan_period[5] <= pwdata[PER_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_NODE_ID:   prdata = {26'd0, cfg.node_id};
      REG_HB_PER:    prdata = {16'd0, cfg.hb_period};
      REG_STATE_PER: prdata = {16'd0, cfg.chan_period[0]};
      REG_ERROR_PER: prdata = {16'd0, cfg.chan_period[1]};
      REG_ENC_PER:   prdata = {16'd0, cfg.chan_period[2]};
      REG_IQ_PER:    prdata = {16'd0, cfg.chan_period[3]};
      REG_TEMP_PER:  prdata = {16'd0, cfg.chan_period[4]};
      REG_VBUS_PER:  prdata = {16'd0, cfg.chan_period[5]};
    endcase
  end

endmodule

// ===== hdl/ctp_engine.sv =====
`timescale 1ns / 1ps
module ctp_engine
  import ctp_pkg::*;
#(
  parameter int unsigned TORQUE_PERIOD = TORQUE_PERIOD_DEF,
  parameter int unsigned LINK_TIMEOUT  = LINK_TIMEOUT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      in_valid,
  input  item_t     in_item,
  output logic      in_take,
  output logic      out_valid,
  input  logic      out_ready,
  output res_t      out_res,
  output eng_stat_t stat
);

  eng_state_t state, state_next;

  logic [CH_W-1:0]   ev;
  logic [TIME_W-1:0] now_ms, last_rx, hb_time;
  logic [NCHAN-1:0]  in_flight, upd_vld;
  logic              rd_vld;
  logic              cur_ready;
  logic              pend_valid;
  res_t              pend;
  res_t              fin_res;

  logic [CH_W-1:0]   raddr;
  logic [TIME_W-1:0] rd_data, upd_time, due, hb_due;
  logic [PER_W-1:0]  period_sel;
  logic              out_free, link_now, ch_hit, hb_hit;
  chan_hit_t         fr_ch;
  res_t              req_res, upd_res;
  logic [31:0]       fr_wa, fr_wb;

  // control decisions for this cycle
  logic take_tick, take_frame, emit, move, flush, advance, done;

  assign out_free = !out_valid || out_ready;
  assign link_now = (now_ms - last_rx) <= TIME_W'(LINK_TIMEOUT);

  assign period_sel = (ev == CH_TORQUE) ? PER_W'(TORQUE_PERIOD) : cfg.chan_period[ev];
  assign upd_time   = rd_vld ? rd_data : '0;
  assign due        = upd_time + {{(TIME_W-PER_W){1'b0}}, period_sel};
  assign ch_hit     = (due < now_ms) && !in_flight[ev];
  assign hb_due     = hb_time + {{(TIME_W-PER_W){1'b0}}, cfg.hb_period};
  assign hb_hit     = hb_due < now_ms;

  assign fr_ch = cmd_chan(in_item.frame_id[CMD_W-1:0]);
  assign fr_wa = (in_item.frame_len == LEN_FULL) ? in_item.frame_data[31:0] : '0;
  assign fr_wb = (in_item.frame_len == LEN_FULL) ? in_item.frame_data[63:32] :
                 (in_item.frame_len == LEN_WORD) ? in_item.frame_data[31:0] : '0;

  always_comb begin
    req_res                  = '0;
    req_res.kind             = KIND_REQ;
    req_res.channel          = (state == ST_HB) ? CH_STATE : ev;
    req_res.out_id           = {cfg.node_id, chan_cmd(req_res.channel)};
    req_res.link_ok          = link_now;

    upd_res                  = '0;
    upd_res.kind             = KIND_UPD;
    upd_res.channel          = fr_ch.ch;
    upd_res.word_a           = fr_wa;
    upd_res.word_b           = fr_wb;
    if (fr_ch.ch == CH_STATE) begin
      upd_res.state_byte  = fr_wb[7:0];
      upd_res.result_byte = fr_wb[15:8];
    end
    // last_rx is stamped with now_ms by this frame, so the link is fresh
    upd_res.link_ok          = 1'b1;
    upd_res.last             = 1'b1;
  end

  // final request of a tick goes out with last set
  always_comb begin
    fin_res      = pend;
    fin_res.last = 1'b1;
  end

  // control outputs
  always_comb begin
    take_tick  = 1'b0;
    take_frame = 1'b0;
    emit       = 1'b0;
    move       = 1'b0;
    flush      = 1'b0;
    advance    = 1'b0;
    done       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_item.action == ACT_TICK) begin
            take_tick = 1'b1;
          end else if (out_free) begin
            take_frame = 1'b1;
          end
        end
      end
      ST_SCAN, ST_HB: begin
        if (((state == ST_SCAN) ? ch_hit : hb_hit)) begin
          if (!pend_valid || out_free) begin
            emit    = 1'b1;
            move    = pend_valid;
            advance = 1'b1;
          end
        end else begin
          advance = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid) begin
          done = 1'b1;
        end else if (out_free) begin
          flush = 1'b1;
          done  = 1'b1;
        end
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (take_tick) state_next = ST_SCAN;
      ST_SCAN:  if (advance && ev == CH_TORQUE) state_next = ST_HB;
      ST_HB:    if (advance) state_next = ST_FLUSH;
      ST_FLUSH: if (done) state_next = ST_IDLE;
    endcase
  end

  assign in_take = take_tick | take_frame;

  // read address runs one channel ahead of the compare; held on a stall
  always_comb begin
    raddr = '0;
    if (state == ST_SCAN) begin
      raddr = (advance && ev != CH_TORQUE) ? ev + 3'd1 : ev;
    end
  end

  ctp_ram #(
    .WIDTH(TIME_W),
    .DEPTH(NCHAN)
  ) u_upd_ram (
    .clk  (clk),
    .we   (take_frame & fr_ch.hit),
    .waddr(fr_ch.ch),
    .wdata(now_ms),
    .raddr(raddr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ev         <= '0;
      now_ms     <= '0;
      last_rx    <= '0;
      hb_time    <= '0;
      in_flight  <= '0;
      upd_vld    <= '0;
      rd_vld     <= 1'b0;
      cur_ready  <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= upd_vld[raddr];

      if (state == ST_IDLE) begin
        ev <= '0;
      end else if (state == ST_SCAN && advance && ev != CH_TORQUE) begin
        ev <= ev + 3'd1;
      end

      if (take_tick) begin
        now_ms    <= now_ms + 32'd1;
        cur_ready <= in_item.tx_ready;
      end

      if (take_frame) begin
        last_rx <= now_ms;
        if (fr_ch.hit) begin
          upd_vld[fr_ch.ch]   <= 1'b1;
          in_flight[fr_ch.ch] <= 1'b0;
        end
      end

      if (state == ST_SCAN && emit && cur_ready) begin
        in_flight[ev] <= 1'b1;
      end
      if (state == ST_HB && emit) begin
        hb_time <= now_ms;
      end

      if (emit) begin
        pend_valid <= 1'b1;
      end else if (flush) begin
        pend_valid <= 1'b0;
      end

      if (flush || move || (take_frame && fr_ch.hit)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pend <= req_res;
    end
    if (flush) begin
      out_res <= fin_res;
    end else if (move) begin
      out_res <= pend;
    end else if (take_frame && fr_ch.hit) begin
      out_res <= upd_res;
    end
  end

  assign stat.idle       = (state == ST_IDLE);
  assign stat.pend_valid = pend_valid;

endmodule

// ===== hdl/can_telemetry_poller.sv =====
`timescale 1ns / 1ps
// A tick holds the sequencer while it takes the beat, scans the seven channels (one
// update-time memory read per channel), checks the heartbeat and releases the final
// request with tlast; output stalls can hold the scan and the release. A received
// frame is taken when the output is free; an input buffer takes the next beat while
// one is in work.
// Reset (rst, synchronous) clears time, flags and queues and loads register defaults.
module can_telemetry_poller
  import ctp_pkg::*;
#(
  parameter int unsigned TORQUE_PERIOD = TORQUE_PERIOD_DEF,
  parameter int unsigned LINK_TIMEOUT  = LINK_TIMEOUT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tx_ready[0], frame_id[11:1], frame_len[15:12], frame_data[79:16]
  input  logic [79:0] s_tdata,
  // action[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_id[10:0], channel[13:11], word_a[45:14], word_b[77:46], state_byte[85:78],
  // result_byte[93:86], link_ok[94], zero[95]
  output logic [95:0] m_tdata,
  // kind[0]
  output logic        m_tuser,
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t      cfg;
  item_t     buf_item, s_item;
  logic      buf_valid, take;
  res_t      res;
  eng_stat_t stat;

  assign s_item.action     = s_tuser;
  assign s_item.tx_ready   = s_tdata[0];
  assign s_item.frame_id   = s_tdata[11:1];
  assign s_item.frame_len  = s_tdata[15:12];
  assign s_item.frame_data = s_tdata[79:16];

  assign s_tready = !buf_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      buf_valid <= 1'b1;
    end else if (take) begin
      buf_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      buf_item <= s_item;
    end
  end

  ctp_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  ctp_engine #(
    .TORQUE_PERIOD(TORQUE_PERIOD),
    .LINK_TIMEOUT (LINK_TIMEOUT)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (buf_valid),
    .in_item  (buf_item),
    .in_take  (take),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_res  (res),
    .stat     (stat)
  );

  assign m_tdata = {1'b0, res.link_ok, res.result_byte, res.state_byte,
                    res.word_b, res.word_a, res.channel, res.out_id};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

`ifndef SYNTH
  a_buf_hold: assert property (@(posedge clk) disable iff (rst)
    buf_valid && !take |=> buf_valid && $stable(buf_item))
    else $error("input buffer lost or changed a waiting beat");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    stat.idle |-> !stat.pend_valid)
    else $error("sequencer idle with a request still pending");

  a_upd_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_UPD |-> m_tlast && res.link_ok)
    else $error("update beat without tlast or with stale link");

  a_take_needs_item: assert property (@(posedge clk) disable iff (rst)
    take |-> buf_valid)
    else $error("sequencer took an item from an empty buffer");
`endif

endmodule

// ===== tb/poller_checker.sv =====
`timescale 1ns / 1ps
module poller_checker
  import ctp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // tx_ready[0], frame_id[11:1], frame_len[15:12], frame_data[79:16]
  input  logic [79:0] s_tdata,
  // action[0]
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // out_id[10:0], channel[13:11], word_a[45:14], word_b[77:46], state_byte[85:78],
  // result_byte[93:86], link_ok[94], zero[95]
  input  logic [95:0] m_tdata,
  // kind[0]
  input  logic        m_tuser,
  input  logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          outstanding
);

  // command per channel, channel 0 in the low bits
  localparam logic [NCHAN-1:0][CMD_W-1:0] POLL_CMD = {CMD_TORQUE, CMD_VBUS, CMD_TEMP,
    CMD_IQ, CMD_ENCODER, CMD_ERROR, CMD_HEARTBEAT};

  // register copy
  logic [NODE_W-1:0] node;
  logic [PER_W-1:0]  hb_per;
  logic [PER_W-1:0]  per [NPER];

  // poller state
  logic [TIME_W-1:0] now_ms;
  logic [TIME_W-1:0] rx_time;
  logic [TIME_W-1:0] hb_time;
  logic [TIME_W-1:0] upd_time [NCHAN];
  logic [NCHAN-1:0]  in_flight;

  res_t pending_out [$];
  res_t beats [8];
  res_t got;
  res_t want;
  int nbeats;
  int hit;
  logic [TIME_W-1:0] due;
  logic [ID_W-1:0]   base;
  logic [CMD_W-1:0]  cmd;
  logic [3:0]        flen;
  logic [63:0]       fdata;
  logic [31:0]       wa;
  logic [31:0]       wb;

  function automatic res_t make_beat(input logic kind, input logic [ID_W-1:0] id,
      input logic [CH_W-1:0] ch, input logic [31:0] word_a, input logic [31:0] word_b,
      input logic [7:0] axis, input logic [7:0] proc_res);
    res_t b;
    logic [TIME_W-1:0] age;
    age = now_ms - rx_time;
    b.kind             = kind;
    b.out_id           = id;
    b.channel          = ch;
    b.word_a           = word_a;
    b.word_b           = word_b;
    b.state_byte       = axis;
    b.result_byte      = proc_res;
    b.link_ok          = (age <= LINK_TIMEOUT_DEF);
    b.last             = 1'b0;
    return b;
  endfunction

  task automatic report(input string what, input logic [31:0] seen, input logic [31:0] ideal);
    if (mismatches < 100)
      $display("%0t: %s: got %0h, want %0h", $realtime, what, seen, ideal);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mismatches = 0;
      node      = '0;
      hb_per    = PERIOD_RST;
      now_ms    = '0;
      rx_time   = '0;
      hb_time   = '0;
      in_flight = '0;
      for (int i = 0; i < NPER; i++) per[i] = PERIOD_RST;
      for (int i = 0; i < NCHAN; i++) upd_time[i] = '0;
      pending_out.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_NODE_ID: node = pwdata[NODE_W-1:0];
          REG_HB_PER:  hb_per = pwdata[PER_W-1:0];
          default:     per[paddr[4:2] - REG_STATE_PER] = pwdata[PER_W-1:0];
        endcase
      end

      if (s_tvalid && s_tready) begin
        nbeats = 0;
        base   = {node, {CMD_W{1'b0}}};
        if (s_tuser == ACT_TICK) begin
          now_ms = now_ms + 1;
          for (int c = 0; c < NCHAN; c++) begin
            if (c < NPER) due = upd_time[c] + TIME_W'(per[c]);
            else due = upd_time[c] + TIME_W'(TORQUE_PERIOD_DEF);
            if (due < now_ms && !in_flight[c]) begin
              beats[nbeats] = make_beat(KIND_REQ, base | ID_W'(POLL_CMD[c]), CH_W'(c),
                                        '0, '0, '0, '0);
              nbeats++;
              // no transmit space: request goes out but is not tracked
              if (s_tdata[0]) in_flight[c] = 1'b1;
            end
          end
          due = hb_time + TIME_W'(hb_per);
          if (due < now_ms) begin
            beats[nbeats] = make_beat(KIND_REQ, base | ID_W'(POLL_CMD[CH_STATE]), CH_STATE,
                                      '0, '0, '0, '0);
            nbeats++;
            hb_time = now_ms;
          end
        end else begin
          cmd   = s_tdata[5:1];
          flen  = s_tdata[15:12];
          fdata = s_tdata[79:16];
          wa    = '0;
          wb    = '0;
          if (flen == LEN_FULL) begin
            wa = fdata[31:0];
            wb = fdata[63:32];
          end else if (flen == LEN_WORD) begin
            wb = fdata[31:0];
          end
          // any frame refreshes the link, even an unknown command
          rx_time = now_ms;
          hit = -1;
          for (int c = 0; c < NCHAN; c++)
            if (POLL_CMD[c] == cmd) hit = c;
          if (hit >= 0) begin
            upd_time[hit]  = now_ms;
            in_flight[hit] = 1'b0;
            if (hit == 0) beats[0] = make_beat(KIND_UPD, '0, CH_STATE, wa, wb, wb[7:0], wb[15:8]);
            else beats[0] = make_beat(KIND_UPD, '0, CH_W'(hit), wa, wb, '0, '0);
            nbeats = 1;
          end
        end
        if (nbeats > 0) beats[nbeats-1].last = 1'b1;
        for (int i = 0; i < nbeats; i++) pending_out.push_back(beats[i]);
      end

      if (m_tvalid && m_tready) begin
        got.kind             = m_tuser;
        got.out_id           = m_tdata[10:0];
        got.channel          = m_tdata[13:11];
        got.word_a           = m_tdata[45:14];
        got.word_b           = m_tdata[77:46];
        got.state_byte       = m_tdata[85:78];
        got.result_byte      = m_tdata[93:86];
        got.link_ok          = m_tdata[94];
        got.last             = m_tlast;
        if (pending_out.size() == 0) begin
          report("beat with nothing pending, out_id", 32'(got.out_id), '0);
        end else begin
          want = pending_out.pop_front();
          if (got.kind !== want.kind) report("kind", 32'(got.kind), 32'(want.kind));
          if (got.out_id !== want.out_id)
            report("out_id", 32'(got.out_id), 32'(want.out_id));
          if (got.channel !== want.channel)
            report("channel", 32'(got.channel), 32'(want.channel));
          if (got.word_a !== want.word_a) report("word_a", got.word_a, want.word_a);
          if (got.word_b !== want.word_b) report("word_b", got.word_b, want.word_b);
          if (got.state_byte !== want.state_byte)
            report("state_byte", 32'(got.state_byte), 32'(want.state_byte));
          if (got.result_byte !== want.result_byte)
            report("result_byte", 32'(got.result_byte), 32'(want.result_byte));
          if (got.link_ok !== want.link_ok)
            report("link_ok", 32'(got.link_ok), 32'(want.link_ok));
          if (got.last !== want.last) report("last", 32'(got.last), 32'(want.last));
        end
      end
    end
    outstanding = pending_out.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import ctp_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 45;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  // tx_ready[0], frame_id[11:1], frame_len[15:12], frame_data[79:16]
  logic [79:0] s_tdata;
  // action[0]
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  // out_id[10:0], channel[13:11], word_a[45:14], word_b[77:46], state_byte[85:78],
  // result_byte[93:86], link_ok[94], zero[95]
  logic [95:0] m_tdata;
  // kind[0]
  logic        m_tuser;
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          mismatches;
  int          outstanding;

  int tx_idle_pct = 31;
  int rx_idle_pct = 62;
  int quiet_cycles = 0;
  logic [NODE_W-1:0] cur_node;

  can_telemetry_poller uut (.*);
  poller_checker chk (.*);

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(negedge clk)
    m_tready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic act, input logic rdy, input logic [10:0] id,
                           input logic [3:0] len, input logic [63:0] data);
    @(negedge clk);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {data, len, id, rdy};
    do @(posedge clk); while (!s_tready);
  endtask

  // let the poller finish: ticks and unknown frames may still be in the sequencer
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // periods packed state first, in the low bits
  task automatic write_settings(input logic [NODE_W-1:0] node, input logic [PER_W-1:0] hb,
                                input logic [NPER*PER_W-1:0] periods);
    apb_write(REG_NODE_ID, 32'(node));
    apb_write(REG_HB_PER, 32'(hb));
    for (int i = 0; i < NPER; i++)
      apb_write(reg_idx_t'(REG_STATE_PER + i), 32'(periods[i*PER_W +: PER_W]));
    cur_node = node;
  endtask

  initial begin
    int roll;
    logic [31:0] rnd;
    logic [63:0] rdata;
    logic [CMD_W-1:0] cmd;
    logic [NODE_W-1:0] nbits;
    logic [3:0] rlen;
    logic [NPER*PER_W-1:0] periods;

    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = ACT_TICK;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    cur_node = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 6; p++) begin
      tx_idle_pct = (p < 2) ? 31 : (p < 4) ? 62 : 0;
      rx_idle_pct = (p < 2) ? 62 : (p < 4) ? 31 : 0;

      if (p == 0) begin
        // reset periods: nothing is due on the first tick
        send_item(ACT_TICK, 1'b1, '0, '0, '0);
        send_item(ACT_FRAME, 1'b0, {6'h3F, CMD_HEARTBEAT}, LEN_FULL, '1);
        send_item(ACT_FRAME, 1'b1, {6'h15, CMD_ERROR}, LEN_WORD, 64'h0123_4567_89AB_CDEF);
        send_item(ACT_FRAME, 1'b0, {6'h00, CMD_ENCODER}, 4'd0, '1);
        send_item(ACT_FRAME, 1'b1, {6'h2A, CMD_IQ}, 4'd9, '1);
        send_item(ACT_FRAME, 1'b0, {6'h01, CMD_TEMP}, 4'd15, '1);
        send_item(ACT_FRAME, 1'b1, {6'h3F, CMD_VBUS}, LEN_FULL, '0);
        send_item(ACT_FRAME, 1'b0, {6'h20, CMD_TORQUE}, LEN_WORD, '1);
        send_item(ACT_FRAME, 1'b1, 11'h000, LEN_FULL, '1);
        send_item(ACT_FRAME, 1'b0, 11'h7FF, LEN_FULL, 64'hFEDC_BA98_7654_3210);
        send_item(ACT_FRAME, 1'b1, {6'h00, CMD_HEARTBEAT}, LEN_WORD, 64'hFFFF_FFFF_0000_5AC3);
        wait_drained();
        // vbus 2, temp max, iq 0, encoder 1, error max, state 0
        write_settings(6'h3F, 16'h0000, {16'd2, 16'hFFFF, 16'd0, 16'd1, 16'hFFFF, 16'd0});
        // transmit full: same requests come back on the next tick
        send_item(ACT_TICK, 1'b0, '1, '1, '1);
        send_item(ACT_TICK, 1'b0, '0, '0, '0);
        send_item(ACT_TICK, 1'b1, '0, '0, '0);
        send_item(ACT_TICK, 1'b1, '1, '1, '1);
        send_item(ACT_FRAME, 1'b0, {6'h3F, CMD_HEARTBEAT}, LEN_FULL, 64'h0000_A55A_0000_0000);
        send_item(ACT_FRAME, 1'b1, {6'h05, CMD_IQ}, LEN_FULL, '1);
        send_item(ACT_TICK, 1'b1, '0, '0, '0);
      end else begin
        wait_drained();
        if (p == 1) begin
          write_settings('0, 16'hFFFF, '0);
        end else begin
          for (int i = 0; i < NPER; i++)
            periods[i*PER_W +: PER_W] = ($urandom_range(9) == 0) ? 16'hFFFF
                                        : PER_W'($urandom_range(30));
          write_settings(NODE_W'($urandom_range(63)), PER_W'($urandom_range(25)), periods);
        end
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        roll  = $urandom_range(99);
        rnd   = $urandom;
        rdata = {$urandom, $urandom};
        rlen  = 4'($urandom_range(15));
        if (roll < 50) begin
          send_item(ACT_TICK, $urandom_range(3) != 0, rnd[10:0], rlen, rdata);
        end else if (roll < 88) begin
          // reply from the controller, usually from our own node
          case ($urandom_range(6))
            0:       cmd = CMD_HEARTBEAT;
            1:       cmd = CMD_ERROR;
            2:       cmd = CMD_ENCODER;
            3:       cmd = CMD_IQ;
            4:       cmd = CMD_TEMP;
            5:       cmd = CMD_VBUS;
            default: cmd = CMD_TORQUE;
          endcase
          nbits = ($urandom_range(7) == 0) ? rnd[16 +: NODE_W] : cur_node;
          if ($urandom_range(9) != 0) rlen = $urandom_range(1) ? LEN_FULL : LEN_WORD;
          send_item(ACT_FRAME, rnd[31], {nbits, cmd}, rlen, rdata);
        end else begin
          send_item(ACT_FRAME, rnd[31], rnd[10:0], rlen, rdata);
        end
      end
    end

    wait_drained();
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ctp_pkg.sv
hdl/ctp_ram.sv
hdl/ctp_regs.sv
hdl/ctp_engine.sv
hdl/can_telemetry_poller.sv
tb/poller_checker.sv
tb/testbench.sv
